### hdl/mecwm_pkg.sv
// Package for the mecanum wheel speed mixer: codes, register indexes,
// sequencer steps and fixed-point constants. No dependencies.
package mecwm_pkg;

    localparam int TRIG_TABLE_BITS_DEF = 10;
    localparam int CFG_INDEX_W = 3;

    localparam logic [CFG_INDEX_W-1:0] REG_VX_GAIN       = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_VY_GAIN       = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_PLAIN_WZ_GAIN = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_FOLLOW_WZ_GAIN = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_SPIN_GAIN_MAX = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_WZ_LIMIT      = 3'd5;

    localparam logic OP_YAW   = 1'b0;
    localparam logic OP_DRIVE = 1'b1;

    localparam logic [1:0] MODE_STOP   = 2'd0;
    localparam logic [1:0] MODE_PLAIN  = 2'd1;
    localparam logic [1:0] MODE_FOLLOW = 2'd2;
    localparam logic [1:0] MODE_SPIN   = 2'd3;

    localparam int STEP_W = 5;
    localparam logic [STEP_W-1:0] STEP_VX     = 5'd0;
    localparam logic [STEP_W-1:0] STEP_VY     = 5'd1;
    localparam logic [STEP_W-1:0] STEP_WZ     = 5'd2;
    localparam logic [STEP_W-1:0] STEP_DIV    = 5'd3;
    localparam logic [STEP_W-1:0] STEP_S_SQ   = 5'd4;
    localparam logic [STEP_W-1:0] STEP_S_P1   = 5'd5;
    localparam logic [STEP_W-1:0] STEP_S_P2   = 5'd6;
    localparam logic [STEP_W-1:0] STEP_S_P3   = 5'd7;
    localparam logic [STEP_W-1:0] STEP_C_SQ   = 5'd8;
    localparam logic [STEP_W-1:0] STEP_C_P1   = 5'd9;
    localparam logic [STEP_W-1:0] STEP_C_P2   = 5'd10;
    localparam logic [STEP_W-1:0] STEP_C_P3   = 5'd11;
    localparam logic [STEP_W-1:0] STEP_ROT_XC = 5'd12;
    localparam logic [STEP_W-1:0] STEP_ROT_YS = 5'd13;
    localparam logic [STEP_W-1:0] STEP_ROT_YC = 5'd14;
    localparam logic [STEP_W-1:0] STEP_ROT_XS = 5'd15;
    localparam logic [STEP_W-1:0] STEP_ROT_END = 5'd16;

    localparam int YAW_FULL = 36000;
    localparam int YAW_HALF = 18000;
    localparam int SPIN_STEP = 205;
    // floor(n / 36000) = (n * DIV_MUL) >> DIV_SHIFT, exact for n < 2^30
    localparam logic [31:0] DIV_MUL = 32'd1954687339;
    localparam int DIV_SHIFT = 46;

    localparam logic [15:0] POLY_C1 = 16'd2383;
    localparam logic [15:0] POLY_C2 = 16'd21077;
    localparam logic [15:0] POLY_C3 = 16'd51466;
    localparam logic [15:0] SINE_MAX = 16'd16384;

    localparam int WHEEL_W = 18;
    localparam int SUM_W = 46;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_RUN  = 4'b0010,
        ST_FIN  = 4'b0100,
        ST_DONE = 4'b1000
    } state_t;

endpackage

### hdl/mecanum_wheel_speed_mixer.sv
// Mecanum wheel speed mixer top level: sequencer around one shared multiplier.
// Depends on mecwm_pkg, mecwm_mul, mecwm_wheel.
// Yaw and stop items go from the accepting edge straight to ST_DONE; plain and follow
// items step VX to DIV; spin items take 17 steps (VX to ROT_END) through the multiplier.
// Items are taken only in ST_IDLE; a stalled output beat holds the input off.
// Reset: asynchronous, active low; registers to defaults, heading, gain, wheels zero.
module mecanum_wheel_speed_mixer #(
    parameter int TRIG_TABLE_BITS = mecwm_pkg::TRIG_TABLE_BITS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               opcode,
    input  logic [1:0]         drive_mode,
    input  logic signed [10:0] stick_vx,
    input  logic signed [10:0] stick_vy,
    input  logic signed [10:0] stick_wz,
    input  logic [15:0]        yaw_raw,
    input  logic [15:0]        yaw_offset,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [17:0] front_right_speed,
    output logic signed [17:0] front_left_speed,
    output logic signed [17:0] back_left_speed,
    output logic signed [17:0] back_right_speed,
    output logic signed [15:0] heading,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [mecwm_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [15:0]        cfg_data
);
    import mecwm_pkg::*;

    localparam int TB = TRIG_TABLE_BITS;
    localparam logic [TB-1:0] QUARTER = TB'(1 << (TB - 2));

    state_t state_reg, state_next;
    logic [STEP_W-1:0] step_reg;

    logic [15:0] vx_gain_reg, vy_gain_reg, plain_gain_reg, follow_gain_reg, spin_max_reg;
    logic [14:0] wz_limit_reg;

    logic signed [15:0] heading_reg;
    logic [15:0]        spin_gain_reg;
    logic signed [17:0] wheel_reg [4];

    logic [1:0]         mode_reg;
    logic signed [10:0] sx_reg, sy_reg, sw_reg;
    logic signed [27:0] vx_reg, vy_reg, wz_reg;
    logic signed [45:0] ax_reg, ay_reg;
    logic [15:0]        xs_reg, xc_reg, x2_reg;
    logic               neg_s_reg, neg_c_reg;
    logic signed [15:0] sin_reg, cos_reg;
    logic               out_valid_reg;

    logic signed [31:0] op_a, op_b;
    logic signed [63:0] prod;
    logic [15:0]        p15;
    logic [15:0]        mag;
    logic signed [15:0] sine_now;
    logic [TB-1:0]      k_s, k_c;
    logic signed [27:0] wz_raw, wz_lim, wz_clamped;
    logic [15:0]        gain_sel;
    logic signed [17:0] hsum, hwrap;
    logic [31:0]        div_num;
    logic [16:0]        spin_inc;
    logic               accept, spin;
    logic signed [45:0] mix_ax, mix_ay, mix_w;
    logic signed [17:0] fr_w, fl_w, bl_w, br_w;

    function automatic logic [15:0] trig_x(input logic [TB-1:0] k);
        logic [TB-2:0] q;
        q = {1'b0, k[TB-3:0]};
        if (k[TB-2])
            q = QUARTER[TB-2:0] - q;
        return 16'(q) << (17 - TB);
    endfunction

    mecwm_mul u_mul (
        .clk  (clk),
        .op_a (op_a),
        .op_b (op_b),
        .prod (prod)
    );

    assign accept    = in_valid && !in_stall;
    assign in_stall  = (state_reg != ST_IDLE);
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign spin      = (mode_reg == MODE_SPIN);

    assign p15  = prod[30:15];
    assign mag  = (prod[31:16] > SINE_MAX) ? SINE_MAX : prod[31:16];
    assign k_s  = prod[DIV_SHIFT +: TB];
    assign k_c  = k_s + QUARTER;
    assign div_num = (32'(17'(heading_reg + 18'sd36000)) << TB) + 32'(YAW_HALF);

    always_comb
    begin
        case (mode_reg)
            MODE_SPIN:   gain_sel = spin_gain_reg;
            MODE_PLAIN:  gain_sel = plain_gain_reg;
            default:     gain_sel = follow_gain_reg;
        endcase
    end

    always_comb
    begin
        sine_now = 16'sd0;
        case (step_reg)
            STEP_C_SQ:   sine_now = neg_s_reg ? -signed'(mag) : signed'(mag);
            STEP_ROT_XC: sine_now = neg_c_reg ? -signed'(mag) : signed'(mag);
            default:     sine_now = 16'sd0;
        endcase
    end

    always_comb
    begin
        op_a = 32'sd0;
        op_b = 32'sd0;
        case (step_reg)
            STEP_VX:     begin op_a = 32'(sx_reg); op_b = signed'(32'(vx_gain_reg)); end
            STEP_VY:     begin op_a = 32'(sy_reg); op_b = signed'(32'(vy_gain_reg)); end
            STEP_WZ:     begin op_a = 32'(sw_reg); op_b = signed'(32'(gain_sel)); end
            STEP_DIV:    begin op_a = signed'(div_num); op_b = signed'(DIV_MUL); end
            STEP_S_SQ:
            begin
                op_a = signed'(32'(trig_x(k_s)));
                op_b = signed'(32'(trig_x(k_s)));
            end
            STEP_S_P1, STEP_C_P1:
            begin
                op_a = signed'(32'(POLY_C1));
                op_b = signed'(32'(p15));
            end
            STEP_S_P2, STEP_C_P2:
            begin
                op_a = signed'(32'(POLY_C2 - p15));
                op_b = signed'(32'(x2_reg));
            end
            STEP_S_P3:   begin op_a = signed'(32'(POLY_C3 - p15)); op_b = signed'(32'(xs_reg)); end
            STEP_C_P3:   begin op_a = signed'(32'(POLY_C3 - p15)); op_b = signed'(32'(xc_reg)); end
            STEP_C_SQ:   begin op_a = signed'(32'(xc_reg)); op_b = signed'(32'(xc_reg)); end
            STEP_ROT_XC: begin op_a = 32'(vx_reg); op_b = 32'(sine_now); end
            STEP_ROT_YS: begin op_a = 32'(vy_reg); op_b = 32'(sin_reg); end
            STEP_ROT_YC: begin op_a = 32'(vy_reg); op_b = 32'(cos_reg); end
            STEP_ROT_XS: begin op_a = 32'(vx_reg); op_b = 32'(sin_reg); end
            default:     begin op_a = 32'sd0; op_b = 32'sd0; end
        endcase
    end

    assign wz_raw = prod[27:0];
    assign wz_lim = signed'(28'({wz_limit_reg, 12'd0}));

    always_comb
    begin
        wz_clamped = wz_raw;
        if (mode_reg == MODE_FOLLOW)
        begin
            if (wz_raw > wz_lim)
                wz_clamped = wz_lim;
            else if (wz_raw < -wz_lim)
                wz_clamped = -wz_lim;
        end
    end

    always_comb
    begin
        if (yaw_raw <= yaw_offset)
            hsum = 18'(signed'({2'b0, yaw_raw})) - 18'(signed'({2'b0, yaw_offset}))
                   + 18'sd36000;
        else if (yaw_raw <= 16'(YAW_FULL))
            hsum = 18'(signed'({2'b0, yaw_raw})) - 18'(signed'({2'b0, yaw_offset}));
        else
            hsum = 18'(heading_reg);
        hwrap = hsum;
        if (hsum >= 18'sd18000 && hsum <= 18'sd36000)
            hwrap = hsum - 18'sd36000;
    end

    assign spin_inc = 17'(spin_gain_reg) + 17'(SPIN_STEP);

    assign mix_ax = spin ? ax_reg : 46'(vx_reg);
    assign mix_ay = spin ? ay_reg : 46'(vy_reg);
    assign mix_w  = spin ? (46'(wz_reg) <<< 14) : 46'(wz_reg);

    mecwm_wheel u_wheel (
        .ax   (mix_ax),
        .ay   (mix_ay),
        .w    (mix_w),
        .spin (spin),
        .fr   (fr_w),
        .fl   (fl_w),
        .bl   (bl_w),
        .br   (br_w)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
                if (accept)
                    state_next = (opcode == OP_DRIVE && drive_mode != MODE_STOP)
                                 ? ST_RUN : ST_DONE;
            ST_RUN:
                if ((step_reg == STEP_DIV && !spin) || step_reg == STEP_ROT_END)
                    state_next = ST_FIN;
            ST_FIN:
                state_next = ST_DONE;
            ST_DONE:
                if (!out_valid_reg || !out_stall)
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            step_reg        <= STEP_VX;
            out_valid_reg   <= 1'b0;
            vx_gain_reg     <= 16'd4096;
            vy_gain_reg     <= 16'd4096;
            plain_gain_reg  <= 16'd4096;
            follow_gain_reg <= 16'd4096;
            spin_max_reg    <= 16'd8192;
            wz_limit_reg    <= 15'd170;
            heading_reg     <= 16'sd0;
            spin_gain_reg   <= 16'd0;
            for (int i = 0; i < 4; i++)
                wheel_reg[i] <= 18'sd0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_VX_GAIN:        vx_gain_reg     <= cfg_data;
                    REG_VY_GAIN:        vy_gain_reg     <= cfg_data;
                    REG_PLAIN_WZ_GAIN:  plain_gain_reg  <= cfg_data;
                    REG_FOLLOW_WZ_GAIN: follow_gain_reg <= cfg_data;
                    REG_SPIN_GAIN_MAX:  spin_max_reg    <= cfg_data;
                    REG_WZ_LIMIT:       wz_limit_reg    <= cfg_data[14:0];
                    default:            ;
                endcase
            end

            if (accept)
            begin
                step_reg <= STEP_VX;
                if (opcode == OP_YAW)
                    heading_reg <= hwrap[15:0];
                else if (drive_mode == MODE_SPIN)
                begin
                    if (spin_gain_reg <= spin_max_reg)
                        spin_gain_reg <= spin_inc[16] ? 16'hFFFF : spin_inc[15:0];
                end
                else
                begin
                    spin_gain_reg <= 16'd0;
                    if (drive_mode == MODE_STOP)
                        for (int i = 0; i < 4; i++)
                            wheel_reg[i] <= 18'sd0;
                end
            end
            else if (state_reg == ST_RUN)
                step_reg <= step_reg + STEP_W'(1);

            if (state_reg == ST_FIN)
            begin
                wheel_reg[0] <= fr_w;
                wheel_reg[1] <= fl_w;
                wheel_reg[2] <= bl_w;
                wheel_reg[3] <= br_w;
            end

            if (state_reg == ST_DONE && (!out_valid_reg || !out_stall))
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mode_reg <= drive_mode;
            sx_reg   <= stick_vx;
            sy_reg   <= stick_vy;
            sw_reg   <= stick_wz;
        end
        if (state_reg == ST_RUN)
        begin
            case (step_reg)
                STEP_VY:     vx_reg <= prod[27:0];
                STEP_WZ:     vy_reg <= prod[27:0];
                STEP_DIV:    wz_reg <= wz_clamped;
                STEP_S_SQ:
                begin
                    xs_reg    <= trig_x(k_s);
                    xc_reg    <= trig_x(k_c);
                    neg_s_reg <= k_s[TB-1];
                    neg_c_reg <= k_c[TB-1];
                end
                STEP_S_P1, STEP_C_P1: x2_reg <= p15;
                STEP_C_SQ:   sin_reg <= sine_now;
                STEP_ROT_XC: cos_reg <= sine_now;
                STEP_ROT_YS: ax_reg <= prod[45:0];
                STEP_ROT_YC: ax_reg <= ax_reg - prod[45:0];
                STEP_ROT_XS: ay_reg <= prod[45:0];
                STEP_ROT_END: ay_reg <= ay_reg + prod[45:0];
                default:     ;
            endcase
        end
        if (state_reg == ST_DONE && (!out_valid_reg || !out_stall))
        begin
            front_right_speed <= wheel_reg[0];
            front_left_speed  <= wheel_reg[1];
            back_left_speed   <= wheel_reg[2];
            back_right_speed  <= wheel_reg[3];
            heading           <= heading_reg;
        end
    end

endmodule

### hdl/mecwm_mul.sv
// Shared 32x32 signed multiplier with registered product.
// Depends on nothing.
module mecwm_mul (
    input  logic               clk,
    input  logic signed [31:0] op_a,
    input  logic signed [31:0] op_b,
    output logic signed [63:0] prod
);

    logic signed [63:0] prod_reg;

    always_ff @(posedge clk)
    begin
        prod_reg <= op_a * op_b;
    end

    assign prod = prod_reg;

endmodule

### hdl/mecwm_wheel.sv
// Wheel mixing: four sums, round half up, saturate to 18 bits.
// Depends on mecwm_pkg.
module mecwm_wheel (
    input  logic signed [45:0] ax,
    input  logic signed [45:0] ay,
    input  logic signed [45:0] w,
    input  logic               spin,
    output logic signed [17:0] fr,
    output logic signed [17:0] fl,
    output logic signed [17:0] bl,
    output logic signed [17:0] br
);
    import mecwm_pkg::*;

    logic signed [SUM_W-1:0] r0, r1, r2, r3;

    function automatic logic signed [WHEEL_W-1:0] rnd_sat(input logic signed [SUM_W-1:0] v,
                                                          input logic sp);
        logic signed [SUM_W-1:0] t;
        t = sp ? ((v + SUM_W'(1 << 25)) >>> 26) : ((v + SUM_W'(1 << 11)) >>> 12);
        if (t > SUM_W'(131071))
            return WHEEL_W'(131071);
        else if (t < -SUM_W'(131072))
            return WHEEL_W'(-131072);
        else
            return t[WHEEL_W-1:0];
    endfunction

    always_comb
    begin
        r0 = -ax - ay - w;
        r1 = ax - ay - w;
        r2 = ax + ay - w;
        r3 = -ax + ay - w;
        fr = rnd_sat(r0, spin);
        fl = rnd_sat(r1, spin);
        bl = rnd_sat(r2, spin);
        br = rnd_sat(r3, spin);
    end

endmodule

### bench/mecanum_wheel_speed_mixer_tb.sv
// Testbench for mecanum_wheel_speed_mixer: directed and random yaw and drive beats,
// checked against a behavioral predictor of heading wrap, gains, rotation and saturation.
// Depends on mecwm_pkg and the mixer RTL.
`timescale 1ns / 100ps

module mecanum_wheel_speed_mixer_tb;
    import mecwm_pkg::*;

    typedef struct packed {
        logic signed [17:0] fr;
        logic signed [17:0] fl;
        logic signed [17:0] bl;
        logic signed [17:0] br;
        logic signed [15:0] hdg;
    } wheel_beat_t;

    localparam int TRIG_BITS = TRIG_TABLE_BITS_DEF;
    localparam int IDLE_LIMIT = 20000;
    localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 3'd7;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    logic opcode;
    logic [1:0] drive_mode;
    logic signed [10:0] stick_vx;
    logic signed [10:0] stick_vy;
    logic signed [10:0] stick_wz;
    logic [15:0] yaw_raw;
    logic [15:0] yaw_offset;
    logic out_valid;
    logic out_stall;
    logic signed [17:0] front_right_speed;
    logic signed [17:0] front_left_speed;
    logic signed [17:0] back_left_speed;
    logic signed [17:0] back_right_speed;
    logic signed [15:0] heading;
    logic cfg_valid;
    logic cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [15:0] cfg_data;

    mecanum_wheel_speed_mixer dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .opcode(opcode), .drive_mode(drive_mode),
        .stick_vx(stick_vx), .stick_vy(stick_vy), .stick_wz(stick_wz),
        .yaw_raw(yaw_raw), .yaw_offset(yaw_offset),
        .out_valid(out_valid), .out_stall(out_stall),
        .front_right_speed(front_right_speed), .front_left_speed(front_left_speed),
        .back_left_speed(back_left_speed), .back_right_speed(back_right_speed),
        .heading(heading),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // predictor state
    longint gain_vx, gain_vy, gain_plain, gain_follow, gain_spin_max, wz_clamp;
    longint heading_q, spin_gain_q;
    longint wheel_q[4];

    wheel_beat_t wheel_expected[$];
    int mismatch_count;
    int idle_cycles;
    int send_idle_pct;
    int recv_stall_pct;
    bit hold_off;
    bit timed_out;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic longint rnd_shift(longint v, int s);
        return (v + (longint'(1) <<< (s - 1))) >>> s;
    endfunction

    function automatic longint clip_wheel(longint v);
        if (v > 131071)
            return 131071;
        if (v < -131072)
            return -131072;
        return v;
    endfunction

    function automatic longint quarter_wave(longint x);
        longint x2, t;
        x2 = (x * x) >> 15;
        t = (2383 * x2) >> 15;
        t = 21077 - t;
        t = (t * x2) >> 15;
        t = 51466 - t;
        t = ((t * x) >> 15) >> 1;
        if (t > 16384)
            t = 16384;
        return t;
    endfunction

    function automatic longint sine_lookup(longint k);
        longint full, quarter, quad, q, s;
        full = longint'(1) << TRIG_BITS;
        quarter = full >> 2;
        k = k & (full - 1);
        quad = k >> (TRIG_BITS - 2);
        q = k & (quarter - 1);
        if (quad & 1)
            q = quarter - q;
        s = quarter_wave(q << (17 - TRIG_BITS));
        return (quad & 2) ? -s : s;
    endfunction

    task automatic predict_reset();
        gain_vx = 4096;
        gain_vy = 4096;
        gain_plain = 4096;
        gain_follow = 4096;
        gain_spin_max = 8192;
        wz_clamp = 170;
        heading_q = 0;
        spin_gain_q = 0;
        foreach (wheel_q[i])
            wheel_q[i] = 0;
    endtask

    task automatic predict_beat(logic op, logic [1:0] md, logic signed [10:0] sx,
                                logic signed [10:0] sy, logic signed [10:0] sw,
                                logic [15:0] yr, logic [15:0] yo);
        longint h, vx, vy, wz, ax, ay, w, lim, k, s, c;
        longint r[4];
        int frac;
        wheel_beat_t e;
        if (op == OP_YAW)
        begin
            h = heading_q;
            if (yr <= yo)
                h = longint'(yr) - longint'(yo) + 36000;
            else if (yr <= 36000)
                h = longint'(yr) - longint'(yo);
            if (h >= 18000 && h <= 36000)
                h -= 36000;
            heading_q = h;
        end
        else if (md == MODE_STOP)
        begin
            spin_gain_q = 0;
            foreach (wheel_q[i])
                wheel_q[i] = 0;
        end
        else
        begin
            vx = longint'(sx) * gain_vx;
            vy = longint'(sy) * gain_vy;
            if (md == MODE_SPIN)
            begin
                if (spin_gain_q <= gain_spin_max)
                begin
                    spin_gain_q += 205;
                    if (spin_gain_q > 65535)
                        spin_gain_q = 65535;
                end
                wz = longint'(sw) * spin_gain_q;
                k = ((heading_q + 36000) * (longint'(1) << TRIG_BITS) + 18000) / 36000;
                s = sine_lookup(k);
                c = sine_lookup(k + ((longint'(1) << TRIG_BITS) >> 2));
                ax = vx * c - vy * s;
                ay = vy * c + vx * s;
                w = wz * 16384;
                frac = 26;
            end
            else
            begin
                spin_gain_q = 0;
                if (md == MODE_PLAIN)
                    wz = longint'(sw) * gain_plain;
                else
                begin
                    lim = wz_clamp * 4096;
                    wz = longint'(sw) * gain_follow;
                    if (wz > lim)
                        wz = lim;
                    if (wz < -lim)
                        wz = -lim;
                end
                ax = vx;
                ay = vy;
                w = wz;
                frac = 12;
            end
            r[0] = -ax - ay - w;
            r[1] = ax - ay - w;
            r[2] = ax + ay - w;
            r[3] = -ax + ay - w;
            foreach (r[i])
                wheel_q[i] = clip_wheel(rnd_shift(r[i], frac));
        end
        e.fr = 18'(wheel_q[0]);
        e.fl = 18'(wheel_q[1]);
        e.bl = 18'(wheel_q[2]);
        e.br = 18'(wheel_q[3]);
        e.hdg = 16'(heading_q);
        wheel_expected.push_back(e);
    endtask

    task automatic send_beat(logic op, logic [1:0] md, logic signed [10:0] sx,
                             logic signed [10:0] sy, logic signed [10:0] sw,
                             logic [15:0] yr, logic [15:0] yo);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct)
            @(posedge clk);
        in_valid <= 1'b1;
        opcode <= op;
        drive_mode <= md;
        stick_vx <= sx;
        stick_vy <= sy;
        stick_wz <= sw;
        yaw_raw <= yr;
        yaw_offset <= yo;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predict_beat(op, md, sx, sy, sw, yr, yo);
        in_valid <= 1'b0;
        // the block holds in_stall high after taking a beat
        @(posedge clk);
    endtask

    task automatic drain();
        while (wheel_expected.size() != 0)
            @(posedge clk);
        repeat (25) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [15:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        case (idx)
            REG_VX_GAIN: gain_vx = longint'(value);
            REG_VY_GAIN: gain_vy = longint'(value);
            REG_PLAIN_WZ_GAIN: gain_plain = longint'(value);
            REG_FOLLOW_WZ_GAIN: gain_follow = longint'(value);
            REG_SPIN_GAIN_MAX: gain_spin_max = longint'(value);
            REG_WZ_LIMIT: wz_clamp = longint'(value[14:0]);
            default: ;
        endcase
        @(posedge clk);
    endtask

    function automatic logic [10:0] rnd_stick();
        case ($urandom_range(7))
            0: return 11'h400;
            1: return 11'h3FF;
            2: return 11'h000;
            default: return 11'($urandom);
        endcase
    endfunction

    function automatic logic [15:0] rnd_angle();
        case ($urandom_range(9))
            0: return 16'($urandom);
            1: return 16'd36000;
            2: return 16'd0;
            default: return 16'($urandom_range(36000));
        endcase
    endfunction

    task automatic send_random(int n);
        logic [1:0] md;
        repeat (n)
        begin
            if ($urandom_range(3) == 0)
                send_beat(OP_YAW, 2'($urandom), 11'($urandom), 11'($urandom),
                          11'($urandom), rnd_angle(), rnd_angle());
            else
            begin
                md = ($urandom_range(9) < 4) ? MODE_SPIN : 2'($urandom);
                send_beat(OP_DRIVE, md, rnd_stick(), rnd_stick(), rnd_stick(),
                          16'($urandom), 16'($urandom));
            end
        end
    endtask

    task automatic test_directed();
        send_beat(OP_DRIVE, MODE_PLAIN, 11'sh3FF, 11'sh3FF, 11'sh3FF, 16'd0, 16'd0);
        send_beat(OP_DRIVE, MODE_PLAIN, 11'sh400, 11'sh3FF, 11'sh400, 16'd0, 16'd0);
        send_beat(OP_DRIVE, MODE_FOLLOW, 11'sd100, -11'sd200, 11'sh3FF, 16'd0, 16'd0);
        send_beat(OP_DRIVE, MODE_FOLLOW, 11'sd100, -11'sd200, 11'sh400, 16'd0, 16'd0);
        send_beat(OP_DRIVE, MODE_STOP, 11'sh3FF, 11'sh3FF, 11'sh3FF, 16'd0, 16'd0);
        send_beat(OP_YAW, MODE_SPIN, 11'sd5, 11'sd5, 11'sd5, 16'd9000, 16'd0);
        send_beat(OP_YAW, MODE_STOP, 11'sd0, 11'sd0, 11'sd0, 16'd0, 16'd36000);
        send_beat(OP_YAW, MODE_STOP, 11'sd0, 11'sd0, 11'sd0, 16'd36000, 16'd0);
        send_beat(OP_YAW, MODE_STOP, 11'sd0, 11'sd0, 11'sd0, 16'd30000, 16'd0);
        send_beat(OP_YAW, MODE_STOP, 11'sd0, 11'sd0, 11'sd0, 16'hFFFF, 16'd100);
        send_beat(OP_YAW, MODE_STOP, 11'sd0, 11'sd0, 11'sd0, 16'd500, 16'hFFFF);
        send_beat(OP_YAW, MODE_STOP, 11'sd0, 11'sd0, 11'sd0, 16'd27000, 16'd0);
        repeat (6)
            send_beat(OP_DRIVE, MODE_SPIN, 11'sd700, -11'sd300, 11'sd900, 16'd0, 16'd0);
        send_beat(OP_YAW, MODE_STOP, 11'sd0, 11'sd0, 11'sd0, 16'd4500, 16'd0);
        send_beat(OP_DRIVE, MODE_SPIN, 11'sh400, 11'sh400, 11'sh400, 16'd0, 16'd0);
        send_beat(OP_DRIVE, MODE_PLAIN, 11'sd0, 11'sd0, 11'sd0, 16'hFFFF, 16'hFFFF);
        drain();
    endtask

    task automatic test_config_extremes();
        write_reg(REG_VX_GAIN, 16'hFFFF);
        write_reg(REG_VY_GAIN, 16'hFFFF);
        write_reg(REG_PLAIN_WZ_GAIN, 16'hFFFF);
        write_reg(REG_FOLLOW_WZ_GAIN, 16'hFFFF);
        write_reg(REG_SPIN_GAIN_MAX, 16'hFFFF);
        write_reg(REG_WZ_LIMIT, 16'h7FFF);
        write_reg(REG_UNUSED, 16'h1234);
        send_random(150);
        drain();
        write_reg(REG_VX_GAIN, 16'd0);
        write_reg(REG_VY_GAIN, 16'd0);
        write_reg(REG_PLAIN_WZ_GAIN, 16'd0);
        write_reg(REG_FOLLOW_WZ_GAIN, 16'd0);
        write_reg(REG_SPIN_GAIN_MAX, 16'd0);
        write_reg(REG_WZ_LIMIT, 16'd0);
        send_random(100);
        drain();
        write_reg(REG_VX_GAIN, 16'($urandom));
        write_reg(REG_VY_GAIN, 16'($urandom));
        write_reg(REG_PLAIN_WZ_GAIN, 16'($urandom));
        write_reg(REG_FOLLOW_WZ_GAIN, 16'($urandom));
        write_reg(REG_SPIN_GAIN_MAX, 16'($urandom_range(20000)));
        write_reg(REG_WZ_LIMIT, 16'($urandom_range(4000)));
    endtask

    task automatic test_idling();
        send_random(200);
        send_idle_pct = 84;
        send_random(150);
        send_idle_pct = 0;
        recv_stall_pct = 84;
        send_random(150);
        send_idle_pct = 12;
        recv_stall_pct = 12;
        send_random(300);
        send_idle_pct = 0;
        recv_stall_pct = 0;
    endtask

    task automatic test_backpressure();
        hold_off = 1'b1;
        send_random(20);
        send_random(1);
        drain();
        send_random(300);
        drain();
    endtask

    // long receiver hold-off while the sender keeps offering beats
    always @(posedge clk)
        if (hold_off)
        begin
            repeat (300) @(posedge clk);
            hold_off <= 1'b0;
        end

    always @(posedge clk)
        if (rst_n)
            out_stall <= hold_off ||
                         (recv_stall_pct > 0 && $urandom_range(99) < recv_stall_pct);

    always @(posedge clk)
    begin
        wheel_beat_t e, got;
        if (rst_n && out_valid && !out_stall)
        begin
            got = {front_right_speed, front_left_speed, back_left_speed,
                   back_right_speed, heading};
            if (wheel_expected.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected beat: %p", got);
            end
            else
            begin
                e = wheel_expected.pop_front();
                if (got != e)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("mismatch: expected %p got %p", e, got);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT && !timed_out)
        begin
            timed_out = 1'b1;
            $display("mecanum_wheel_speed_mixer_tb: errors");
            $finish;
        end
    end

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        out_stall = 1'b0;
        opcode = OP_YAW;
        drive_mode = MODE_STOP;
        stick_vx = '0;
        stick_vy = '0;
        stick_wz = '0;
        yaw_raw = '0;
        yaw_offset = '0;
        cfg_valid = 1'b0;
        cfg_index = REG_VX_GAIN;
        cfg_data = '0;
        mismatch_count = 0;
        idle_cycles = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_off = 1'b0;
        timed_out = 1'b0;
        predict_reset();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_config_extremes();
        test_idling();
        test_backpressure();
        drain();
        if (mismatch_count == 0 && wheel_expected.size() == 0)
            $display("mecanum_wheel_speed_mixer_tb: clean");
        else
            $display("mecanum_wheel_speed_mixer_tb: errors");
        $finish;
    end
endmodule
